FILE: design/rcws_pkg.sv
// Shared types and codes for the RGB colour wheel stepper.
`default_nettype none

package rcws_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned LEAD_W  = 2;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned MODE_W  = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_DERIVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

  // Leading channel positions
  localparam logic [LEAD_W-1:0] LEAD_RED   = 2'd0;
  localparam logic [LEAD_W-1:0] LEAD_GREEN = 2'd1;
  localparam logic [LEAD_W-1:0] LEAD_BLUE  = 2'd2;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [LEAD_W-1:0]  lead_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    lead_t  lead;
    level_t cap;
    level_t base;
  } wheel_t;

endpackage

`default_nettype wire

FILE: design/rcws_step_unit.sv
// Shared hue step unit: one rise, fall or position move per use.
`default_nettype none

module rcws_step_unit (
  input  rcws_pkg::wheel_t cur,
  output rcws_pkg::wheel_t nxt
);

  rcws_pkg::lead_t  lead_pos;
  rcws_pkg::lead_t  next_pos;
  rcws_pkg::level_t lead_lvl;
  rcws_pkg::level_t next_lvl;
  rcws_pkg::level_t rise_lvl;
  rcws_pkg::level_t fall_lvl;
  logic             do_rise;
  logic             do_fall;

  always_comb begin
    lead_pos = (cur.lead == rcws_pkg::LEAD_RED || cur.lead == rcws_pkg::LEAD_GREEN ||
                cur.lead == rcws_pkg::LEAD_BLUE) ? cur.lead : rcws_pkg::LEAD_RED;
    case (lead_pos)
      rcws_pkg::LEAD_RED: begin
        next_pos = rcws_pkg::LEAD_GREEN;
        lead_lvl = cur.red;
        next_lvl = cur.green;
      end
      rcws_pkg::LEAD_GREEN: begin
        next_pos = rcws_pkg::LEAD_BLUE;
        lead_lvl = cur.green;
        next_lvl = cur.blue;
      end
      default: begin
        next_pos = rcws_pkg::LEAD_RED;
        lead_lvl = cur.blue;
        next_lvl = cur.red;
      end
    endcase

    do_rise  = (next_lvl != cur.cap);
    do_fall  = !do_rise && (lead_lvl != cur.base);
    rise_lvl = next_lvl + rcws_pkg::level_t'(1);
    fall_lvl = lead_lvl - rcws_pkg::level_t'(1);

    nxt = cur;
    if (do_rise) begin
      case (next_pos)
        rcws_pkg::LEAD_RED:   nxt.red   = rise_lvl;
        rcws_pkg::LEAD_GREEN: nxt.green = rise_lvl;
        default:              nxt.blue  = rise_lvl;
      endcase
    end else if (do_fall) begin
      case (lead_pos)
        rcws_pkg::LEAD_RED:   nxt.red   = fall_lvl;
        rcws_pkg::LEAD_GREEN: nxt.green = fall_lvl;
        default:              nxt.blue  = fall_lvl;
      endcase
    end else begin
      nxt.lead = next_pos;
    end
  end

endmodule

`default_nettype wire

FILE: design/rgb_color_wheel_stepper_core.sv
// Top level of the RGB colour wheel stepper: sequencer, state and handshakes.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | into core | in_valid / in_ready | mode, red/green/blue_in, lead_in,
//          |           |                     | cap_in, base_in, step_count
//  out     | out       | out_valid/out_ready | red_out, green_out, blue_out, lead_out
//
// Derive, load and unused-mode beats go straight to the result; an advance beat
// latches its count, then takes one hue step per cycle through the shared step
// unit until the count runs out (a zero count skips the steps). The result sits in the
// state registers until taken; the next input beat is accepted the cycle after.
// Reset clears colour, position, cap and base to zero and returns to idle.
// A stalled output holds everything still; no input is taken meanwhile.
`default_nettype none

module rgb_color_wheel_stepper_core #(
  parameter int unsigned COUNT_W = rcws_pkg::COUNT_W
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [rcws_pkg::MODE_W-1:0]  mode,
  input  wire  [rcws_pkg::LEVEL_W-1:0] red_in,
  input  wire  [rcws_pkg::LEVEL_W-1:0] green_in,
  input  wire  [rcws_pkg::LEVEL_W-1:0] blue_in,
  input  wire  [rcws_pkg::LEAD_W-1:0]  lead_in,
  input  wire  [rcws_pkg::LEVEL_W-1:0] cap_in,
  input  wire  [rcws_pkg::LEVEL_W-1:0] base_in,
  input  wire  [COUNT_W-1:0]           step_count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [rcws_pkg::LEVEL_W-1:0] red_out,
  output logic [rcws_pkg::LEVEL_W-1:0] green_out,
  output logic [rcws_pkg::LEVEL_W-1:0] blue_out,
  output logic [rcws_pkg::LEAD_W-1:0]  lead_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  rcws_pkg::wheel_t wheel;
  rcws_pkg::wheel_t wheel_next;
  rcws_pkg::wheel_t stepped;
  rcws_pkg::wheel_t derived;
  rcws_pkg::level_t lo_rg;
  rcws_pkg::level_t hi_rg;
  rcws_pkg::lead_t  pos_rg;
  logic             in_beat;

  rcws_step_unit u_step (
    .cur (wheel),
    .nxt (stepped)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign in_beat   = in_valid && in_ready;
  assign red_out   = wheel.red;
  assign green_out = wheel.green;
  assign blue_out  = wheel.blue;
  assign lead_out  = wheel.lead;

  // Derive base, cap and the first maximum channel, ties going to the earlier one.
  always_comb begin
    lo_rg  = (green_in < red_in) ? green_in : red_in;
    hi_rg  = (green_in > red_in) ? green_in : red_in;
    pos_rg = (green_in > red_in) ? rcws_pkg::LEAD_GREEN : rcws_pkg::LEAD_RED;
    derived.red   = red_in;
    derived.green = green_in;
    derived.blue  = blue_in;
    derived.base  = (blue_in < lo_rg) ? blue_in : lo_rg;
    derived.cap   = (blue_in > hi_rg) ? blue_in : hi_rg;
    derived.lead  = (blue_in > hi_rg) ? rcws_pkg::LEAD_BLUE : pos_rg;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    wheel_next = wheel;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          case (mode)
            rcws_pkg::MODE_DERIVE: begin
              wheel_next = derived;
              state_next = ST_DONE;
            end
            rcws_pkg::MODE_LOAD: begin
              wheel_next.red   = red_in;
              wheel_next.green = green_in;
              wheel_next.blue  = blue_in;
              wheel_next.cap   = cap_in;
              wheel_next.base  = base_in;
              // Fold an out-of-range position back to red
              wheel_next.lead  = (lead_in == rcws_pkg::LEAD_RED ||
                                  lead_in == rcws_pkg::LEAD_GREEN ||
                                  lead_in == rcws_pkg::LEAD_BLUE) ?
                                 lead_in : rcws_pkg::LEAD_RED;
              state_next = ST_DONE;
            end
            rcws_pkg::MODE_ADVANCE: begin
              count_next = step_count;
              state_next = (step_count == '0) ? ST_DONE : ST_RUN;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_RUN: begin
        // Advance one hue step per cycle until the count runs out
        wheel_next = stepped;
        count_next = count - COUNT_W'(1);
        if (count == COUNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/rcws_checker.sv
// Port-level assertions for the RGB colour wheel stepper, bound to the top level.
`default_nettype none

module rcws_checker #(
  parameter int unsigned COUNT_W = rcws_pkg::COUNT_W
) (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire [rcws_pkg::MODE_W-1:0]  mode,
  input wire [COUNT_W-1:0]           step_count,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [rcws_pkg::LEVEL_W-1:0] red_out,
  input wire [rcws_pkg::LEVEL_W-1:0] green_out,
  input wire [rcws_pkg::LEVEL_W-1:0] blue_out,
  input wire [rcws_pkg::LEAD_W-1:0]  lead_out
);

  // One item at a time: never take input while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // Derive, load, unused mode and zero-step advances show a result the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode != rcws_pkg::MODE_ADVANCE || step_count == '0))
    |=> out_valid)
    else $error("short item did not produce a result next cycle");

  // Position stays on a real channel whenever shown
  a_lead_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lead_out != 2'd3))
    else $error("lead position out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(red_out) && $stable(green_out)
                                   && $stable(blue_out) && $stable(lead_out)))
    else $error("stalled result changed");

endmodule

bind rgb_color_wheel_stepper_core rcws_checker #(.COUNT_W(COUNT_W)) u_rcws_checker (.*);

`default_nettype wire
